// File: rtl/pcc_pkg.sv
// Shared types, constants and register codes for the pixel color correction block.
package pcc_pkg;

    // Pipeline stage positions
    localparam int NSTG      = 9;
    localparam int ST_GAIN   = 0;
    localparam int ST_CLAMP  = 1;
    localparam int ST_MIX    = 2;
    localparam int ST_SUM    = 3;
    localparam int ST_SQ     = 4;
    localparam int ST_CURVE  = 5;
    localparam int ST_WGT    = 6;
    localparam int ST_ACC    = 7;
    localparam int ST_OUT    = 8;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // Payload and register types
    typedef logic signed [15:0] t_pix_in;
    typedef logic signed [23:0] t_pix_out;
    typedef logic        [23:0] t_gain;
    typedef logic signed [15:0] t_bright;
    typedef logic signed [15:0] t_contrast;
    typedef logic signed [15:0] t_coef;
    typedef logic        [47:0] t_row;
    typedef logic        [14:0] t_chan;   // clamped channel, 0..16384 in Q.14
    typedef logic signed [19:0] t_mixed;  // matrix output in Q.14, unclamped

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN     = 3'd0,
        CFG_BRIGHT   = 3'd1,
        CFG_CONTRAST = 3'd2,
        CFG_ROW_RED  = 3'd3,
        CFG_ROW_GRN  = 3'd4,
        CFG_ROW_BLU  = 3'd5
    } t_cfg_idx;

    // Reset values
    localparam t_gain     RST_GAIN    = 24'd65536;
    localparam t_row      RST_ROW_RED = 48'h0000_0000_1000;
    localparam t_row      RST_ROW_GRN = 48'h0000_1000_0000;
    localparam t_row      RST_ROW_BLU = 48'h1000_0000_0000;

    // Fixed-point constants
    localparam logic [28:0] ONE_Q28   = 29'h1000_0000;
    localparam int          HALF_Q14  = 8192;
    localparam int          ONE_Q14   = 16384;
    localparam int          OUT_MAX   = 8388607;
    localparam int          OUT_MIN   = -8388608;

endpackage

// File: rtl/pcc_if.sv
// Stream interfaces for input and corrected output pixels.
interface pcc_pix_in_if import pcc_pkg::*; ();
    logic    valid;
    logic    ready;
    t_pix_in red_in;
    t_pix_in green_in;
    t_pix_in blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

interface pcc_pix_out_if import pcc_pkg::*; ();
    logic     valid;
    logic     ready;
    t_pix_out red_out;
    t_pix_out green_out;
    t_pix_out blue_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    output ready);
endinterface

// File: rtl/pcc_front.sv
// Per-channel front end: exposure gain, brightness offset, clamp and round to Q.14.
module pcc_front import pcc_pkg::*; (
    input  logic            i_clk,
    input  logic [NSTG-1:0] i_adv,
    input  t_pix_in         i_smp,
    input  t_gain           i_gain,
    input  t_bright         i_bright,
    output t_chan           o_chan
);

    logic signed [40:0] r_prod;
    logic signed [40:0] n_prod;
    logic signed [41:0] w_sum;
    logic        [28:0] w_clamp;
    logic        [29:0] w_rnd;
    t_chan              r_chan;
    t_chan              n_chan;

    // Gain multiply, exact in Q.28
    assign n_prod = 41'(i_smp) * 41'($signed({1'b0, i_gain}));

    // Offset, clamp to [0, 1] and round half up
    always_comb begin
        w_sum = 42'(r_prod) + 42'($signed({i_bright, 13'd0}));
        if (w_sum[41]) begin
            w_clamp = '0;
        end else if (w_sum > $signed({13'd0, ONE_Q28})) begin
            w_clamp = ONE_Q28;
        end else begin
            w_clamp = w_sum[28:0];
        end
        w_rnd  = {1'b0, w_clamp} + 30'(HALF_Q14);
        n_chan = w_rnd[28:14];
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[ST_GAIN]) begin
            r_prod <= n_prod;
        end
        if (i_adv[ST_CLAMP]) begin
            r_chan <= n_chan;
        end
    end

    assign o_chan = r_chan;

endmodule

// File: rtl/pcc_tone.sv
// Per-channel tone stage: S-curve, contrast blend, round and saturate to Q9.14.
module pcc_tone import pcc_pkg::*; (
    input  logic            i_clk,
    input  logic [NSTG-1:0] i_adv,
    input  t_mixed          i_mix,
    input  t_contrast       i_contrast,
    output t_pix_out        o_res
);

    // Square stage
    logic               w_sel;
    logic signed [20:0] w_dist;
    logic signed [41:0] n_sq;
    logic        [38:0] r_sq;
    logic               r_sel;
    t_mixed             r_mix;

    // Curve stage
    logic        [39:0] w_two;
    logic signed [40:0] n_s;
    logic signed [40:0] r_s;
    logic signed [16:0] w_absc;
    logic signed [16:0] w_wt;
    logic signed [36:0] n_wm;
    logic signed [36:0] r_wm;

    // Weight stage
    logic signed [40:0] n_pl;
    logic signed [32:0] n_ph;
    logic signed [40:0] r_pl;
    logic signed [32:0] r_ph;
    logic signed [36:0] r_wm2;

    // Sum and output stages
    logic signed [59:0] n_acc;
    logic signed [59:0] r_acc;
    logic signed [59:0] w_rnd;
    logic signed [31:0] w_r;
    t_pix_out           n_res;
    t_pix_out           r_res;

    // Distance from the nearer end of the curve, then square it
    always_comb begin
        w_sel  = (i_mix >= 20'(HALF_Q14));
        w_dist = w_sel ? (21'(ONE_Q14) - 21'(i_mix)) : 21'(i_mix);
        n_sq   = 42'(w_dist) * 42'(w_dist);
    end

    // S-curve value in Q.28 and linear weight term
    always_comb begin
        w_two  = {r_sq, 1'b0};
        n_s    = r_sel ? ($signed({12'd0, ONE_Q28}) - $signed({1'b0, w_two}))
                       : $signed({1'b0, w_two});
        w_absc = i_contrast[15] ? -17'(i_contrast) : 17'(i_contrast);
        w_wt   = 17'(ONE_Q14) - w_absc;
        n_wm   = 37'(w_wt) * 37'(r_mix);
    end

    // Contrast times curve, split into two partial products
    always_comb begin
        n_pl = 41'(i_contrast) * 41'($signed({1'b0, r_s[23:0]}));
        n_ph = 33'(i_contrast) * 33'($signed(r_s[40:24]));
    end

    // Full blend in Q.42
    assign n_acc = (60'(r_ph) <<< 24) + 60'(r_pl) + (60'(r_wm2) <<< 14);

    // Round half up to Q.14 and saturate
    always_comb begin
        w_rnd = r_acc + 60'sd134217728;
        w_r   = $signed(w_rnd[59:28]);
        if (w_r > 32'(OUT_MAX)) begin
            n_res = 24'(OUT_MAX);
        end else if (w_r < 32'(OUT_MIN)) begin
            n_res = 24'(OUT_MIN);
        end else begin
            n_res = w_r[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[ST_SQ]) begin
            r_sq  <= n_sq[38:0];
            r_sel <= w_sel;
            r_mix <= i_mix;
        end
        if (i_adv[ST_CURVE]) begin
            r_s  <= n_s;
            r_wm <= n_wm;
        end
        if (i_adv[ST_WGT]) begin
            r_pl  <= n_pl;
            r_ph  <= n_ph;
            r_wm2 <= r_wm;
        end
        if (i_adv[ST_ACC]) begin
            r_acc <= n_acc;
        end
        if (i_adv[ST_OUT]) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

// File: rtl/pixel_color_correction.sv
// Top level of the pixel color correction pipeline.
//
// Usage:
//   i_pix carries one RGB pixel (signed Q3.12 per channel) per transaction,
//   o_pix one corrected pixel (signed Q9.14, saturated). Every input
//   transaction gives exactly one output transaction, in order.
//   Settings are written through i_cfg_we / i_cfg_idx / i_cfg_data while the
//   pipeline is empty; unknown indexes are ignored.
// Pipeline:
//   Nine register stages: gain, clamp, matrix products, matrix sum, square,
//   curve, contrast products, blend sum, round/saturate. With no stall one
//   pixel per clock is sustained.
//   The 16x41 contrast-times-curve product is split into 16x25 and 16x17
//   partial products; no multiplier takes more than 25 bits per operand.
// Reset:
//   Synchronous, active low: the pipeline empties and the settings return to
//   unity gain, zero offset, zero contrast and an identity matrix.
// Stall:
//   Each stage holds while it is full and the stage after it cannot move, so
//   bubbles collapse; i_pix.ready drops only when all nine stages are full
//   and o_pix is stalled. Nothing is dropped or repeated.
module pixel_color_correction import pcc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pcc_pix_in_if.sink            i_pix,
    pcc_pix_out_if.source         o_pix,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Settings
    t_gain     r_gain;
    t_bright   r_bright;
    t_contrast r_contrast;
    t_row      r_row_red;
    t_row      r_row_grn;
    t_row      r_row_blu;

    // Pipeline control
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_adv;

    // Datapath
    t_pix_in            w_smp  [3];
    t_chan              w_chan [3];
    t_row               w_row  [3];
    logic signed [31:0] r_mp   [3][3];
    t_mixed             r_mix  [3];
    t_pix_out           w_res  [3];
    logic signed [33:0] w_acc  [3];
    t_mixed             n_mix  [3];

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain     <= RST_GAIN;
            r_bright   <= '0;
            r_contrast <= '0;
            r_row_red  <= RST_ROW_RED;
            r_row_grn  <= RST_ROW_GRN;
            r_row_blu  <= RST_ROW_BLU;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_GAIN:     r_gain     <= i_cfg_data[23:0];
                CFG_BRIGHT:   r_bright   <= i_cfg_data[15:0];
                CFG_CONTRAST: r_contrast <= i_cfg_data[15:0];
                CFG_ROW_RED:  r_row_red  <= i_cfg_data[47:0];
                CFG_ROW_GRN:  r_row_grn  <= i_cfg_data[47:0];
                CFG_ROW_BLU:  r_row_blu  <= i_cfg_data[47:0];
                default: begin
                end
            endcase
        end
    end

    // Stage advance: a stage loads when it is empty or its successor moves
    always_comb begin
        w_adv[NSTG-1] = !r_vld[NSTG-1] || o_pix.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_pix.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign i_pix.ready = w_adv[0];

    assign w_smp[0] = i_pix.red_in;
    assign w_smp[1] = i_pix.green_in;
    assign w_smp[2] = i_pix.blue_in;

    assign w_row[0] = r_row_red;
    assign w_row[1] = r_row_grn;
    assign w_row[2] = r_row_blu;

    // Front end per channel
    for (genvar g = 0; g < 3; g++) begin : g_front
        pcc_front u_front (
            .i_clk    (i_clk),
            .i_adv    (w_adv),
            .i_smp    (w_smp[g]),
            .i_gain   (r_gain),
            .i_bright (r_bright),
            .o_chan   (w_chan[g])
        );
    end

    // Matrix sum, rounded half up from Q.26 to Q.14
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_acc[r] = 34'(r_mp[r][0]) + 34'(r_mp[r][1]) + 34'(r_mp[r][2])
                     + 34'sd2048;
            n_mix[r] = w_acc[r][31:12];
        end
    end

    // Matrix products and sums
    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            if (w_adv[ST_MIX]) begin
                for (int j = 0; j < 3; j++) begin
                    r_mp[r][j] <= 32'($signed(w_row[r][16*j +: 16]))
                                * 32'($signed({1'b0, w_chan[j]}));
                end
            end
            if (w_adv[ST_SUM]) begin
                r_mix[r] <= n_mix[r];
            end
        end
    end

    // Tone curve per channel
    for (genvar g = 0; g < 3; g++) begin : g_tone
        pcc_tone u_tone (
            .i_clk      (i_clk),
            .i_adv      (w_adv),
            .i_mix      (r_mix[g]),
            .i_contrast (r_contrast),
            .o_res      (w_res[g])
        );
    end

    assign o_pix.valid     = r_vld[ST_OUT];
    assign o_pix.red_out   = w_res[0];
    assign o_pix.green_out = w_res[1];
    assign o_pix.blue_out  = w_res[2];

endmodule

// File: rtl/pcc_checker.sv
// Port-level checks for the pixel color correction block, bound to the top level.
module pcc_checker import pcc_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     i_in_ready,
    input logic     i_out_valid,
    input logic     i_out_ready,
    input t_pix_out i_red,
    input t_pix_out i_green,
    input t_pix_out i_blue
);

    logic w_in_acc;
    assign w_in_acc = i_in_valid && i_in_ready;

    // Pipeline is empty right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // Input can only be held off when the output is full and stalled
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("input stalled while output can move");

    // Stalled output holds its transaction
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_red) && $stable(i_green) && $stable(i_blue)))
        else $error("stalled output changed");

    // With the receiver always ready an accepted pixel comes out once it has passed every pipeline stage
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_out_ready) ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready
            ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready
            ##1 i_out_ready |=> i_out_valid)
        else $error("pixel missing after pipeline latency");

endmodule

bind pixel_color_correction pcc_checker u_pcc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_red       (o_pix.red_out),
    .i_green     (o_pix.green_out),
    .i_blue      (o_pix.blue_out)
);
